@@ design/srcc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync record CRC-32 checker package
// Shared types, codes and CRC helpers for the record checker.
// ----------------------------------------------------------------------------
package srcc_pkg;

  localparam int unsigned MAX_RECORD = 1024;
  localparam int unsigned POS_W      = 10;
  localparam int unsigned LEN_W      = 11;
  localparam int unsigned CNT_W      = 16;
  localparam int unsigned CRC_W      = 32;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned IDX_W      = 2;

  localparam logic [CRC_W-1:0] CRC_POLY       = 32'hEDB88320;
  localparam logic [CRC_W-1:0] SYNC_RESET     = 32'hAA44121C;
  localparam logic [LEN_W-1:0] LEN_RESET      = 11'd112;
  localparam logic [CNT_W-1:0] LIMIT_RESET    = 16'd3984;
  localparam logic [LEN_W-1:0] LEN_MIN        = 11'd8;
  localparam logic [LEN_W-1:0] LEN_MAX        = LEN_W'(MAX_RECORD);
  localparam logic [POS_W-1:0] POS_AFTER_SYNC = 10'd4;

  localparam logic [IDX_W-1:0] REG_SYNC_WORD     = 2'd0;
  localparam logic [IDX_W-1:0] REG_RECORD_LENGTH = 2'd1;
  localparam logic [IDX_W-1:0] REG_SEARCH_LIMIT  = 2'd2;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_BAD   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOHDR = 2'd2;

  typedef enum logic {
    ST_HUNT,
    ST_RECORD
  } state_t;

  typedef struct packed {
    logic [CRC_W-1:0]    computed_crc;
    logic [CRC_W-1:0]    received_crc;
    logic [STATUS_W-1:0] status;
  } result_t;

  function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0]  crc,
                                                input logic [DATA_W-1:0] b);
    logic [CRC_W-1:0] t;
    t = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      if (t[0]) begin
        t = (t >> 1) ^ CRC_POLY;
      end else begin
        t = t >> 1;
      end
    end
    return {8'd0, crc[31:8]} ^ t;
  endfunction

  // CRC of the four sync bytes, oldest byte first, from a zero start.
  function automatic logic [CRC_W-1:0] crc_sync(input logic [CRC_W-1:0] w);
    logic [CRC_W-1:0] c;
    c = crc_byte('0, w[31:24]);
    c = crc_byte(c, w[23:16]);
    c = crc_byte(c, w[15:8]);
    c = crc_byte(c, w[7:0]);
    return c;
  endfunction

endpackage

@@ design/srcc_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync record CRC-32 checker core
// Sync hunt, record CRC and tail capture; one byte per step.
// ----------------------------------------------------------------------------
module srcc_core
  import srcc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                step,
  input  logic [DATA_W-1:0]   data_byte,
  input  logic [CRC_W-1:0]    sync_word,
  input  logic [LEN_W-1:0]    record_length,
  input  logic [CNT_W-1:0]    search_limit,
  output logic                emit,
  output result_t             result
);

  state_t           st_r, st_nxt;
  logic [CRC_W-1:0] win_r, win_nxt;
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [CRC_W-1:0] crc_r, crc_nxt;
  logic [CRC_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic [CRC_W-1:0] win_shift;
  logic [CNT_W-1:0] cnt_inc;
  logic             match;
  logic             limit_hit;
  logic [LEN_W-1:0] eff_len;
  logic [LEN_W:0]   pos_ext;
  logic             in_body;
  logic             rec_end;

  assign win_shift = {win_r[23:0], data_byte};
  assign cnt_inc   = cnt_r + CNT_W'(1);
  assign match     = (win_shift == sync_word);
  assign limit_hit = (cnt_inc == search_limit);
  assign pos_ext   = {2'b00, pos_r};
  assign in_body   = ((pos_ext + (LEN_W+1)'(4)) < {1'b0, eff_len});
  assign rec_end   = ((pos_ext + (LEN_W+1)'(1)) >= {1'b0, eff_len});

  always_comb begin
    eff_len = record_length;
    if (record_length < LEN_MIN) begin
      eff_len = LEN_MIN;
    end else if (record_length > LEN_MAX) begin
      eff_len = LEN_MAX;
    end
  end

  always_comb begin
    st_nxt = st_r;
    if (step) begin
      unique case (st_r)
        ST_HUNT: begin
          if (match) begin
            st_nxt = ST_RECORD;
          end
        end
        ST_RECORD: begin
          if (rec_end) begin
            st_nxt = ST_HUNT;
          end
        end
        default: st_nxt = ST_HUNT;
      endcase
    end
  end

  always_comb begin
    win_nxt  = win_r;
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    unique case (st_r)
      ST_HUNT: begin
        win_nxt = win_shift;
        if (match) begin
          crc_nxt  = crc_sync(win_shift);
          tail_nxt = '0;
          pos_nxt  = POS_AFTER_SYNC;
          cnt_nxt  = '0;
        end else if (limit_hit) begin
          cnt_nxt = '0;
        end else begin
          cnt_nxt = cnt_inc;
        end
      end
      ST_RECORD: begin
        if (in_body) begin
          crc_nxt = crc_byte(crc_r, data_byte);
        end else begin
          tail_nxt = {data_byte, tail_r[31:8]};
        end
        if (rec_end) begin
          pos_nxt = '0;
          win_nxt = '0;
          cnt_nxt = '0;
        end else begin
          pos_nxt = pos_r + POS_W'(1);
        end
      end
      default: ;
    endcase
  end

  always_comb begin
    emit   = 1'b0;
    result = '0;
    unique case (st_r)
      ST_HUNT: begin
        if (!match && limit_hit) begin
          emit          = step;
          result.status = STATUS_NOHDR;
        end
      end
      ST_RECORD: begin
        if (rec_end) begin
          emit                = step;
          result.status       = (tail_nxt == crc_nxt) ? STATUS_OK : STATUS_BAD;
          result.received_crc = tail_nxt;
          result.computed_crc = crc_nxt;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= ST_HUNT;
      win_r  <= '0;
      pos_r  <= '0;
      crc_r  <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      st_r <= st_nxt;
      if (step) begin
        win_r  <= win_nxt;
        pos_r  <= pos_nxt;
        crc_r  <= crc_nxt;
        tail_r <= tail_nxt;
        cnt_r  <= cnt_nxt;
      end
    end
  end

  a_record_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RECORD |-> cnt_r == '0)
    else $error("Search count runs inside a record.");

  a_record_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_RECORD |-> pos_r >= POS_AFTER_SYNC)
    else $error("Record position below the sync length.");

  a_hunt_pos: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_HUNT |-> pos_r == '0)
    else $error("Position not cleared while hunting.");

  a_close_to_hunt: assert property (@(posedge clk) disable iff (!rst_n)
    (emit && st_r == ST_RECORD) |=> st_r == ST_HUNT)
    else $error("Record result without return to hunting.");

endmodule

@@ design/sync_record_crc32_checker_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sync record CRC-32 checker
// Hunts for a sync word, checks a reflected CRC-32 per record, reports status.
// ----------------------------------------------------------------------------
// A result reaches out_tvalid through the input register, then the result
// register. Throughput: one byte per cycle, but bytes wait while a full
// result register is not taken; the byte-wide CRC step is one XOR network.
// Reset: synchronous active-low rst_n clears both stages, the hunt state and
// loads the register defaults; nothing needs a clearing pass.
module sync_record_crc32_checker_unit
  import srcc_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [7:0]        in_tdata,   // [7:0] data_byte
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [71:0]       out_tdata,  // [1:0] status, [33:2] received_crc,
                                        // [65:34] computed_crc, [71:66] zero
  input  logic              cfg_wr_en,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [CRC_W-1:0]  cfg_wdata
);

  logic [CRC_W-1:0]  sync_word_r;
  logic [LEN_W-1:0]  record_length_r;
  logic [CNT_W-1:0]  search_limit_r;

  logic              in_vld_r;
  logic [DATA_W-1:0] in_byte_r;
  logic              out_vld_r;
  result_t           out_res_r;

  logic              advance;
  logic              emit;
  result_t           result;

  assign advance    = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready  = !in_vld_r || advance;
  assign out_tvalid = out_vld_r;
  assign out_tdata  = {6'd0, out_res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_word_r     <= SYNC_RESET;
      record_length_r <= LEN_RESET;
      search_limit_r  <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SYNC_WORD:     sync_word_r     <= cfg_wdata;
        REG_RECORD_LENGTH: record_length_r <= cfg_wdata[LEN_W-1:0];
        REG_SEARCH_LIMIT:  search_limit_r  <= cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata[DATA_W-1:0];
    end
  end

  srcc_core u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .step          (advance),
    .data_byte     (in_byte_r),
    .sync_word     (sync_word_r),
    .record_length (record_length_r),
    .search_limit  (search_limit_r),
    .emit          (emit),
    .result        (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (!out_vld_r || out_tready) begin
      out_vld_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= result;
    end
  end

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> in_vld_r)
    else $error("Held request lost from the input register.");

  a_emit_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> (!out_vld_r || out_tready))
    else $error("Result produced while the result register is full.");

endmodule

@@ sim/sync_record_crc32_checker_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the sync record CRC-32 checker
// Streams bytes with sync-framed records into the checker and predicts every
// status result (ok, bad checksum, missing header) from its own model of
// the hunt, the reflected CRC-32 and the little-endian tail. Results are
// compared field by field in order. Register settings change between phases,
// and both stream sides idle at random outside the last phase.
// ----------------------------------------------------------------------------
module sync_record_crc32_checker_unit_tb;
  import srcc_pkg::*;

  localparam int unsigned          RUN_LIMIT    = 1_000_000;
  localparam int unsigned          DRAIN_CYCLES = 4;
  localparam int unsigned          PRINT_LIMIT  = 50;
  localparam logic [IDX_W-1:0]     REG_SPARE    = 2'd3;

  class record_scoreboard;
    logic [31:0] sync_word;
    logic [10:0] rec_len;
    logic [15:0] hunt_limit;
    logic [31:0] window;
    logic        in_record;
    logic [9:0]  pos;
    logic [31:0] crc_acc;
    logic [31:0] tail;
    logic [15:0] hunt_cnt;
    result_t     pending[$];
    int unsigned errors, bytes_seen, predicted;
    int unsigned ok_cnt, bad_cnt, nohdr_cnt;

    function new();
      sync_word  = SYNC_RESET;
      rec_len    = LEN_RESET;
      hunt_limit = LIMIT_RESET;
      window     = '0;
      in_record  = 1'b0;
      pos        = '0;
      crc_acc    = '0;
      tail       = '0;
      hunt_cnt   = '0;
      errors     = 0;
      bytes_seen = 0;
      predicted  = 0;
      ok_cnt     = 0;
      bad_cnt    = 0;
      nohdr_cnt  = 0;
    endfunction

    static function logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc ^ {24'd0, b};
      for (int k = 0; k < 8; k++) begin
        c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
    endfunction

    function int unsigned eff_len();
      int unsigned l;
      l = rec_len;
      if (l < LEN_MIN) l = LEN_MIN;
      if (l > MAX_RECORD) l = MAX_RECORD;
      return l;
    endfunction

    function void set_reg(input logic [IDX_W-1:0] idx, input logic [31:0] v);
      case (idx)
        REG_SYNC_WORD: begin
          sync_word = v;
        end
        REG_RECORD_LENGTH: begin
          rec_len = v[10:0];
        end
        REG_SEARCH_LIMIT: begin
          hunt_limit = v[15:0];
        end
        default: begin
        end
      endcase
    endfunction

    function void push_result(input logic [1:0] s, input logic [31:0] rx,
                              input logic [31:0] calc);
      result_t r;
      r.status       = s;
      r.received_crc = rx;
      r.computed_crc = calc;
      pending.push_back(r);
      predicted++;
    endfunction

    function void accept_byte(input logic [7:0] b);
      int unsigned span, p;
      logic [31:0] c;
      span = eff_len();
      bytes_seen++;
      if (!in_record) begin
        window   = {window[23:0], b};
        hunt_cnt = hunt_cnt + 16'd1;
        if (window == sync_word) begin
          c = '0;
          for (int i = 3; i >= 0; i--) begin
            c = crc_step(c, window[8*i +: 8]);
          end
          crc_acc   = c;
          tail      = '0;
          pos       = POS_AFTER_SYNC;
          in_record = 1'b1;
          hunt_cnt  = '0;
        end else if (hunt_cnt == hunt_limit) begin
          hunt_cnt = '0;
          push_result(STATUS_NOHDR, '0, '0);
        end
      end else begin
        p = pos;
        if (p + 4 < span) begin
          crc_acc = crc_step(crc_acc, b);
        end else begin
          tail = {b, tail[31:8]};
        end
        if (p + 1 >= span) begin
          push_result((tail == crc_acc) ? STATUS_OK : STATUS_BAD, tail, crc_acc);
          in_record = 1'b0;
          pos       = '0;
          window    = '0;
          hunt_cnt  = '0;
        end else begin
          pos = 10'(p + 1);
        end
      end
    endfunction

    task report(input string what, input logic [31:0] got, input logic [31:0] want);
      errors++;
      if (errors <= PRINT_LIMIT) begin
        $display("[%0t] %s: got %h, want %h", $time, what, got, want);
      end
    endtask

    task check_status(input logic [71:0] d);
      result_t got, want;
      got = d[65:0];
      if (pending.size() == 0) begin
        report("result with no request behind it", d[31:0], '0);
        return;
      end
      want = pending.pop_front();
      if (got.status != want.status) begin
        report("status", 32'(got.status), 32'(want.status));
      end
      if (got.received_crc != want.received_crc) begin
        report("received_crc", got.received_crc, want.received_crc);
      end
      if (got.computed_crc != want.computed_crc) begin
        report("computed_crc", got.computed_crc, want.computed_crc);
      end
      if (d[71:66] != '0) report("tdata padding", 32'(d[71:66]), '0);
      case (want.status)
        STATUS_OK:  ok_cnt++;
        STATUS_BAD: bad_cnt++;
        default:    nohdr_cnt++;
      endcase
    endtask
  endclass

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              in_tvalid  = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata   = '0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [71:0]       out_tdata;
  logic              cfg_wr_en  = 1'b0;
  logic [IDX_W-1:0]  cfg_index  = '0;
  logic [CRC_W-1:0]  cfg_wdata  = '0;

  record_scoreboard  sb = new();
  int unsigned       in_idle_pct  = 9;
  int unsigned       out_idle_pct = 79;
  int unsigned       reg_writes   = 0;
  int unsigned       cycle_cnt    = 0;

  sync_record_crc32_checker_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99, 0) >= out_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) sb.accept_byte(in_tdata);
      if (out_tvalid && out_tready) sb.check_status(out_tdata);
    end
  end

  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99, 0) < in_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_noise(input int unsigned n, input bit no_ff);
    for (int unsigned i = 0; i < n; i++) begin
      send_byte(no_ff ? 8'($urandom_range(254, 0)) : 8'($urandom));
    end
  endtask

  // A record under the current settings: sync word oldest byte first, random
  // payload, then the CRC as a little-endian tail. A nonzero cut stops early.
  task automatic send_record(input bit corrupt, input int unsigned cut);
    logic [31:0] word, c;
    logic [7:0]  b;
    int unsigned n, sent;
    word = sb.sync_word;
    n    = sb.eff_len();
    c    = '0;
    sent = 0;
    for (int unsigned i = 0; i < n - 4; i++) begin
      if (cut != 0 && sent >= cut) return;
      b = (i < 4) ? word[31 - 8*i -: 8] : 8'($urandom);
      c = record_scoreboard::crc_step(c, b);
      send_byte(b);
      sent++;
    end
    if (corrupt) c = c ^ (32'd1 << $urandom_range(31, 0));
    for (int i = 0; i < 4; i++) begin
      if (cut != 0 && sent >= cut) return;
      send_byte(c[8*i +: 8]);
      sent++;
    end
  endtask

  // Registers change only once no request is still in flight.
  task automatic settle();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [31:0] v);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    sb.set_reg(idx, v);
    reg_writes++;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  task automatic shuffle_settings(input bit all);
    logic [31:0] v;
    settle();
    if (all || $urandom_range(1, 0) == 1) begin
      case ($urandom_range(9, 0))
        0:       v = '0;
        1:       v = '1;
        2:       v = SYNC_RESET;
        default: v = $urandom();
      endcase
      write_reg(REG_SYNC_WORD, v);
    end
    if (all || $urandom_range(1, 0) == 1) begin
      v = ($urandom_range(7, 0) == 0) ? $urandom_range(7, 0) : $urandom_range(32, 8);
      write_reg(REG_RECORD_LENGTH, v | ($urandom() & ~32'h7FF));
    end
    if (all || $urandom_range(1, 0) == 1) begin
      case ($urandom_range(5, 0))
        0:       v = 1;
        1:       v = 16'hFFFF;
        default: v = $urandom_range(48, 2);
      endcase
      write_reg(REG_SEARCH_LIMIT, v | ($urandom() & ~32'hFFFF));
    end
  endtask

  initial begin
    int unsigned base_bytes, base_res;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: short records, extreme bytes and settings, the corner cases.
    write_reg(REG_RECORD_LENGTH, 8);
    write_reg(REG_SEARCH_LIMIT, 6);
    write_reg(REG_SYNC_WORD, 32'hFFFF_FFFF);
    write_reg(REG_SPARE, 32'hDEAD_BEEF);
    send_record(1'b0, 0);
    send_record(1'b1, 0);
    send_noise(6, 1'b1);
    send_noise(2, 1'b1);
    send_record(1'b0, 0);
    settle();
    write_reg(REG_SYNC_WORD, SYNC_RESET);
    write_reg(REG_RECORD_LENGTH, 0);
    send_record(1'b0, 0);
    settle();
    write_reg(REG_RECORD_LENGTH, 20);
    send_record(1'b0, 14);
    settle();
    write_reg(REG_RECORD_LENGTH, 8);
    send_noise(1, 1'b0);
    send_record(1'b0, 6);
    settle();
    write_reg(REG_RECORD_LENGTH, 16);
    send_noise(10, 1'b0);
    settle();
    // Long records are started and then closed early by a shorter length.
    write_reg(REG_RECORD_LENGTH, 11'h7FF);
    send_record(1'b0, 40);
    settle();
    write_reg(REG_RECORD_LENGTH, 8);
    send_noise(1, 1'b0);
    settle();
    write_reg(REG_RECORD_LENGTH, MAX_RECORD);
    write_reg(REG_SEARCH_LIMIT, 16'hFFFF);
    send_record(1'b1, 40);
    settle();
    write_reg(REG_RECORD_LENGTH, 8);
    write_reg(REG_SYNC_WORD, 32'h0);
    send_record(1'b0, 0);

    // Random part in three pacing phases.
    for (int ph = 0; ph < 3; ph++) begin
      settle();
      in_idle_pct  = (ph == 0) ? 9 : (ph == 1) ? 79 : 0;
      out_idle_pct = (ph == 0) ? 79 : (ph == 1) ? 9 : 0;
      if (ph == 2) begin
        // A zero limit wraps the 16-bit count, so a short burst raises no report.
        write_reg(REG_SYNC_WORD, 32'hFFFF_FFFF);
        write_reg(REG_SEARCH_LIMIT, 0);
        send_noise(24, 1'b1);
      end
      shuffle_settings(1'b1);
      base_bytes = sb.bytes_seen;
      base_res   = sb.predicted;
      while (sb.bytes_seen - base_bytes < 120 || sb.predicted - base_res < 12) begin
        case ($urandom_range(99, 0)) inside
          [0:7]:   shuffle_settings(1'b0);
          [8:67]:  send_record($urandom_range(4, 0) == 0, 0);
          [68:87]: send_noise($urandom_range(8, 1), 1'b0);
          default: send_record(1'b0, $urandom_range(sb.eff_len() - 1, 1));
        endcase
      end
    end

    settle();
    repeat (2 * DRAIN_CYCLES) @(negedge clk);
    $display("Sent %0d bytes; %0d good records, %0d bad records, %0d missing headers.",
             sb.bytes_seen, sb.ok_cnt, sb.bad_cnt, sb.nohdr_cnt);
    $display("%0d register writes over three pacing phases; %0d mismatches.",
             reg_writes, sb.errors);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
